/* src/warc_pkg.sv */
// ----------------------------------------------------------------------------
// warc_pkg
// shared widths, register indexes and types of the windowed aimd rate controller
// ----------------------------------------------------------------------------
package warc_pkg;

  localparam int RATE_W    = 32;
  localparam int RUN_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LEN  = 2'd2;

  localparam logic [RATE_W-1:0] MAX_RATE_RST = 32'hFFFF_FFFF;
  localparam logic [RATE_W-1:0] MIN_RATE_RST = 32'd1000;
  localparam logic [RUN_W-1:0]  RUN_LEN_RST  = 16'd120;
  // max(3/4 of the reset ceiling, reset floor)
  localparam logic [RATE_W-1:0] RATE_RST     = 32'hBFFF_FFFF;

  // candidate rates for the next step, already bounded
  typedef struct packed {
    logic [RATE_W-1:0] inc_rate;
    logic [RATE_W-1:0] dec_rate;
  } warc_step_t;

endpackage

/* src/warc_in_if.sv */
// ----------------------------------------------------------------------------
// warc_in_if
// frame outcome channel: valid, ready and the shown flag
// ----------------------------------------------------------------------------
interface warc_in_if;
  logic valid;
  logic ready;
  logic shown;

  modport source (output valid, output shown, input ready);
  modport sink   (input valid, input shown, output ready);
endinterface

/* src/warc_out_if.sv */
// ----------------------------------------------------------------------------
// warc_out_if
// rate update channel: valid, ready and the result fields
// ----------------------------------------------------------------------------
interface warc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rate_budget;
  logic [31:0] drop_total;
  logic        rate_cut;
  logic        rate_raised;

  modport source (output valid, output rate_budget, output drop_total,
                  output rate_cut, output rate_raised, input ready);
  modport sink   (input valid, input rate_budget, input drop_total,
                  input rate_cut, input rate_raised, output ready);
endinterface

/* src/warc_scale.sv */
// ----------------------------------------------------------------------------
// warc_scale
// bounded 105% increase and 80% decrease of the current rate
// ----------------------------------------------------------------------------
module warc_scale (
  input  logic [warc_pkg::RATE_W-1:0] rate_i,
  input  logic [warc_pkg::RATE_W-1:0] max_rate_i,
  input  logic [warc_pkg::RATE_W-1:0] min_rate_i,
  output warc_pkg::warc_step_t        step_o
);
  import warc_pkg::*;

  localparam logic [RATE_W-1:0] RECIP5 = 32'h3333_3333;

  // floor(y/5): reciprocal estimate is low by at most one, fixed by one compare
  function automatic logic [RATE_W-1:0] div5(input logic [RATE_W-1:0] y);
    logic [2*RATE_W-1:0] prod;
    logic [RATE_W-1:0]   qa;
    logic [RATE_W-1:0]   rem;
    prod = (2*RATE_W)'(y) * (2*RATE_W)'(RECIP5);
    qa   = prod[2*RATE_W-1:RATE_W];
    rem  = y - (qa + (qa << 2));
    return (rem >= RATE_W'(5)) ? qa + RATE_W'(1) : qa;
  endfunction

  logic [RATE_W-1:0] q5;
  logic [2:0]        rem5;
  logic [1:0]        frac;
  logic [RATE_W-1:0] dec_raw;
  logic [RATE_W-1:0] q20;
  logic [RATE_W:0]   inc_raw;

  always_comb begin
    // 80%: floor(4r/5) = 4*floor(r/5) + floor(4*(r mod 5)/5)
    q5      = div5(rate_i);
    rem5    = 3'(rate_i - (q5 + (q5 << 2)));
    case (rem5)
      3'd2:    frac = 2'd1;
      3'd3:    frac = 2'd2;
      3'd4:    frac = 2'd3;
      default: frac = 2'd0;
    endcase
    dec_raw = (q5 << 2) + RATE_W'(frac);
    step_o.dec_rate = (dec_raw < min_rate_i) ? min_rate_i : dec_raw;

    // 105%: r + floor(r/20), at least one more, capped
    q20     = div5(rate_i >> 2);
    inc_raw = {1'b0, rate_i} + {1'b0, q20};
    if (q20 == '0) begin
      inc_raw = {1'b0, rate_i} + (RATE_W+1)'(1);
    end
    step_o.inc_rate = (inc_raw > {1'b0, max_rate_i}) ? max_rate_i : inc_raw[RATE_W-1:0];
  end

endmodule

/* src/windowed_aimd_rate_controller.sv */
// ----------------------------------------------------------------------------
// windowed_aimd_rate_controller
// additive-increase / multiplicative-decrease byte rate control over a
// sliding window of frame outcomes
// ----------------------------------------------------------------------------
// Each input beat carries one frame outcome (shown or dropped) and produces
// exactly one output beat with the byte budget for the next frame, the
// saturating dropped-frame total and flags for a cut or a raise step. The
// block takes one beat per clock: all state updates happen in the cycle the
// input beat is accepted and the result lands in an output register. The
// input stays ready while the output register is empty or being drained in
// the same cycle. The last WINDOW_LEN outcomes sit in a shift line of flops;
// a cut empties the window by clearing its fill and miss counts. Writing
// max_rate reloads the current rate with max(3/4 of max_rate, min_rate);
// configuration is to be written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module windowed_aimd_rate_controller #(
  parameter int WINDOW_LEN = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [warc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [warc_pkg::CFG_W-1:0]     cfg_wdata_i,
  warc_in_if.sink                        in_i,
  warc_out_if.source                     out_o
);
  import warc_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WINDOW_LEN);
  // misses*10 > WINDOW_LEN  <=>  misses > floor(WINDOW_LEN/10)
  localparam logic [FILL_W-1:0] MISS_LIMIT = FILL_W'(WINDOW_LEN / 10);

  // configuration
  logic [RATE_W-1:0] max_rate_q;
  logic [RATE_W-1:0] min_rate_q;
  logic [RUN_W-1:0]  run_len_q;

  // controller state
  logic [WINDOW_LEN-1:0] win_q;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [FILL_W-1:0]     misses_q, misses_d;
  logic [RUN_W-1:0]      run_q, run_d;
  logic [RATE_W-1:0]     rate_q, rate_d;
  logic [RATE_W-1:0]     drops_q, drops_d;

  // output register
  logic              out_valid_q;
  logic [RATE_W-1:0] out_rate_q;
  logic [RATE_W-1:0] out_drops_q;
  logic              out_cut_q;
  logic              out_raised_q;

  logic              in_fire;
  logic              miss;
  logic [FILL_W-1:0] fill_push;
  logic [FILL_W-1:0] misses_push;
  logic [RUN_W-1:0]  run_inc;
  logic              do_raise;
  logic              do_cut;
  logic [RATE_W-1:0] init_rate;
  logic [RATE_W-1:0] ceil_quarter;
  warc_step_t        step;

  // skid-free output stage: accept while the result register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  warc_scale u_scale (
    .rate_i     (rate_q),
    .max_rate_i (max_rate_q),
    .min_rate_i (min_rate_q),
    .step_o     (step)
  );

  // reload value for a max_rate write: floor(3m/4) = m - ceil(m/4)
  always_comb begin
    ceil_quarter = (cfg_wdata_i >> 2) + RATE_W'(cfg_wdata_i[1:0] != 2'b00);
    init_rate    = cfg_wdata_i - ceil_quarter;
    if (init_rate < min_rate_q) begin
      init_rate = min_rate_q;
    end
  end

  always_comb begin
    miss = ~in_i.shown;

    // push the outcome into the window; oldest entry leaves once full
    if (fill_q != FILL_FULL) begin
      fill_push   = fill_q + FILL_W'(1);
      misses_push = misses_q + FILL_W'(miss);
    end else begin
      fill_push   = fill_q;
      misses_push = misses_q - FILL_W'(win_q[WINDOW_LEN-1]) + FILL_W'(miss);
    end

    run_inc  = (run_q != '1) ? run_q + RUN_W'(1) : run_q;
    do_raise = in_i.shown && (run_inc >= run_len_q);
    do_cut   = miss && (fill_push == FILL_FULL) && (misses_push > MISS_LIMIT);

    fill_d   = fill_push;
    misses_d = misses_push;
    rate_d   = rate_q;
    drops_d  = drops_q;
    run_d    = run_inc;

    if (in_i.shown) begin
      if (do_raise) begin
        rate_d = step.inc_rate;
        run_d  = '0;
      end
    end else begin
      run_d = '0;
      if (drops_q != '1) begin
        drops_d = drops_q + RATE_W'(1);
      end
      if (do_cut) begin
        // window cleared: only the fill count and miss count matter
        rate_d   = step.dec_rate;
        fill_d   = '0;
        misses_d = '0;
      end
    end
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q  <= MAX_RATE_RST;
      min_rate_q  <= MIN_RATE_RST;
      run_len_q   <= RUN_LEN_RST;
      fill_q      <= '0;
      misses_q    <= '0;
      run_q       <= '0;
      rate_q      <= RATE_RST;
      drops_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MAX_RATE: begin
            max_rate_q <= cfg_wdata_i;
          end
          REG_MIN_RATE: begin
            min_rate_q <= cfg_wdata_i;
          end
          REG_RUN_LEN: begin
            run_len_q <= cfg_wdata_i[RUN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      // a max_rate write reloads the rate
      if (cfg_we_i && (cfg_idx_i == REG_MAX_RATE)) begin
        rate_q <= init_rate;
      end else if (in_fire) begin
        rate_q <= rate_d;
      end
      if (in_fire) begin
        fill_q   <= fill_d;
        misses_q <= misses_d;
        run_q    <= run_d;
        drops_q  <= drops_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // outcome shift line and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_q        <= {win_q[WINDOW_LEN-2:0], miss};
      out_rate_q   <= rate_d;
      out_drops_q  <= drops_d;
      out_cut_q    <= do_cut;
      out_raised_q <= do_raise;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.rate_budget = out_rate_q;
  assign out_o.drop_total  = out_drops_q;
  assign out_o.rate_cut    = out_cut_q;
  assign out_o.rate_raised = out_raised_q;

endmodule

/* bench/windowed_aimd_rate_controller_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_aimd_rate_controller_test
// self-checking bench for the windowed aimd rate controller: frame outcome
// beats in, rate update beats out, each update checked field by field against
// a cycle-free model of the window, run counter, rate and drop total
// ----------------------------------------------------------------------------
package warc_test_pkg;

  localparam int WIN_LEN   = 64;
  localparam int RAISE_PCT = 105;
  localparam int CUT_PCT   = 80;
  localparam int MAX_SHOWN = 100;

  // index with no register behind it
  localparam logic [warc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [warc_pkg::RATE_W-1:0] rate_budget;
    logic [warc_pkg::RATE_W-1:0] drop_total;
    logic                        rate_cut;
    logic                        rate_raised;
  } rate_update_t;

  class rate_scoreboard;
    bit [warc_pkg::RATE_W-1:0] max_rate;
    bit [warc_pkg::RATE_W-1:0] min_rate;
    bit [warc_pkg::RUN_W-1:0]  run_len;

    bit                        miss_line[WIN_LEN];
    int unsigned               head;
    int unsigned               fill;
    int unsigned               misses;
    bit [warc_pkg::RUN_W-1:0]  clean_run;
    bit [warc_pkg::RATE_W-1:0] rate;
    bit [warc_pkg::RATE_W-1:0] drops;

    rate_update_t              update_q[$];
    int unsigned               errors;
    int unsigned               checked;

    function new();
      max_rate  = warc_pkg::MAX_RATE_RST;
      min_rate  = warc_pkg::MIN_RATE_RST;
      run_len   = warc_pkg::RUN_LEN_RST;
      clean_run = '0;
      drops     = '0;
      errors    = 0;
      checked   = 0;
      clear_window();
      reload_rate();
    endfunction

    function void clear_window();
      foreach (miss_line[i]) miss_line[i] = 1'b0;
      head   = 0;
      fill   = 0;
      misses = 0;
    endfunction

    // max(3/4 of the ceiling, floor), product kept wide
    function void reload_rate();
      logic [63:0] wide;
      wide = 64'(max_rate) * 64'd3 / 64'd4;
      if (wide < 64'(min_rate)) wide = 64'(min_rate);
      rate = wide[warc_pkg::RATE_W-1:0];
    endfunction

    function void write_reg(logic [warc_pkg::CFG_IDX_W-1:0] idx,
                            logic [warc_pkg::CFG_W-1:0] data);
      case (idx)
        warc_pkg::REG_MAX_RATE: begin
          max_rate = data;
          reload_rate();
        end
        warc_pkg::REG_MIN_RATE: min_rate = data;
        warc_pkg::REG_RUN_LEN:  run_len  = data[warc_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return update_q.size();
    endfunction

    // one accepted frame outcome -> one expected rate update
    function void note_frame(logic shown);
      logic [63:0]  wide;
      rate_update_t upd;
      bit           miss;
      miss            = !shown;
      upd.rate_cut    = 1'b0;
      upd.rate_raised = 1'b0;
      if (fill < WIN_LEN) begin
        miss_line[(head + fill) % WIN_LEN] = miss;
        fill++;
      end else begin
        misses         -= miss_line[head];
        miss_line[head] = miss;
        head            = (head + 1) % WIN_LEN;
      end
      misses += miss;
      if (shown) begin
        if (clean_run != '1) clean_run++;
        if (clean_run >= run_len) begin
          wide = 64'(rate) * 64'(RAISE_PCT) / 64'(MAX_SHOWN);
          if (wide == 64'(rate)) wide++;
          if (wide > 64'(max_rate)) wide = 64'(max_rate);
          rate            = wide[warc_pkg::RATE_W-1:0];
          clean_run       = '0;
          upd.rate_raised = 1'b1;
        end
      end else begin
        if (drops != '1) drops++;
        clean_run = '0;
        if (fill >= WIN_LEN && misses * 10 > WIN_LEN) begin
          wide = 64'(rate) * 64'(CUT_PCT) / 64'(MAX_SHOWN);
          if (wide < 64'(min_rate)) wide = 64'(min_rate);
          rate         = wide[warc_pkg::RATE_W-1:0];
          upd.rate_cut = 1'b1;
          clear_window();
        end
      end
      upd.rate_budget = rate;
      upd.drop_total  = drops;
      update_q.insert(update_q.size(), upd);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 100)
        $display("update %0d: %s got %h expected %h", checked, what, got, want);
    endtask

    task check_update(rate_update_t got);
      rate_update_t want;
      checked++;
      if (update_q.size() == 0) begin
        report("update with nothing outstanding, rate_budget", got.rate_budget, '0);
        return;
      end
      want = update_q[0];
      update_q.delete(0);
      if (got.rate_budget !== want.rate_budget)
        report("rate_budget", got.rate_budget, want.rate_budget);
      if (got.drop_total !== want.drop_total)
        report("drop_total", got.drop_total, want.drop_total);
      if (got.rate_cut !== want.rate_cut)
        report("rate_cut", 32'(got.rate_cut), 32'(want.rate_cut));
      if (got.rate_raised !== want.rate_raised)
        report("rate_raised", 32'(got.rate_raised), 32'(want.rate_raised));
    endtask
  endclass

endpackage

module windowed_aimd_rate_controller_test;
  import warc_test_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 4;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 200;
  // longest quiet stretch allowed: well above any receiver stall, sender gap
  // or config pause
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [warc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [warc_pkg::CFG_W-1:0]     cfg_wdata;

  warc_in_if  frame_ch ();
  warc_out_if update_ch ();

  windowed_aimd_rate_controller #(
    .WINDOW_LEN (WIN_LEN)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (frame_ch),
    .out_o       (update_ch)
  );

  rate_scoreboard sb = new();

  // stimulus shaping state
  int unsigned run_hint;   // current raise run length, steers clean segment length
  int unsigned seg_left;   // beats left in the current outcome segment
  int unsigned drop_pct;   // drop chance inside the current segment
  int unsigned burst_left; // beats left before the sender takes a gap
  bit          quiet;      // sender never idles in this phase
  int unsigned rx_mode;    // receiver stall pattern
  int unsigned stall_left  = 0;
  int unsigned rx_tick     = 0;
  int unsigned idle_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // receiver: ready pattern chosen per phase
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    rx_tick++;
    if (stall_left != 0) begin
      stall_left--;
      update_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: update_ch.ready <= 1'b1;
        1: update_ch.ready <= ($urandom_range(0, 99) < 65);
        2: begin
          // mostly ready, now and then a long stall
          if ($urandom_range(0, 15) == 0) begin
            stall_left      = $urandom_range(1, 11);
            update_ch.ready <= 1'b0;
          end else begin
            update_ch.ready <= 1'b1;
          end
        end
        default: update_ch.ready <= (rx_tick % 7 != 3) && (rx_tick % 7 != 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled at the rising edge, plus the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (frame_ch.valid && frame_ch.ready)
        sb.note_frame(frame_ch.shown);
      if (update_ch.valid && update_ch.ready)
        sb.check_update({update_ch.rate_budget, update_ch.drop_total,
                         update_ch.rate_cut, update_ch.rate_raised});
      if ((frame_ch.valid && frame_ch.ready) || (update_ch.valid && update_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks, entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_frame(input logic shown);
    frame_ch.valid <= 1'b1;
    frame_ch.shown <= shown;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid and hold off until every update has come back
  task automatic drain();
    frame_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // registers only change while nothing is in flight
  task automatic go_idle();
    drain();
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [warc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [warc_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    if (idx == warc_pkg::REG_RUN_LEN) run_hint = data[warc_pkg::RUN_W-1:0];
    @(negedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // clean runs near the raise length, lossy stretches that fill the window
  // with misses, and short noisy bursts
  function automatic logic pick_shown();
    int unsigned kind;
    int unsigned lo;
    int unsigned hi;
    if (seg_left == 0) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        lo = run_hint / 2;
        hi = run_hint + run_hint / 2 + 2;
        if (hi > 300) hi = 300;
        if (lo > hi) lo = hi;
        seg_left = $urandom_range(lo, hi);
        if (seg_left == 0) seg_left = 1;
        drop_pct = 0;
      end else if (kind < 9) begin
        seg_left = $urandom_range(8, 80);
        drop_pct = $urandom_range(15, 45);
      end else begin
        seg_left = $urandom_range(1, 20);
        drop_pct = 50;
      end
    end
    seg_left--;
    return ($urandom_range(0, 99) >= drop_pct);
  endfunction

  task automatic send_stream(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      // one full hold-off mid phase
      if (n == count / 2) drain();
      if (!quiet) begin
        if (burst_left == 0) begin
          frame_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk_i);
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
      end
      send_frame(pick_shown());
    end
  endtask

  task automatic set_phase(input int unsigned p);
    logic [warc_pkg::CFG_W-1:0] ceiling;
    ceiling = $urandom;
    go_idle();
    case (p)
      0: begin
        write_reg(warc_pkg::REG_MIN_RATE, 32'd1000);
        write_reg(warc_pkg::REG_RUN_LEN,  32'd120);
        write_reg(warc_pkg::REG_MAX_RATE, '1);
      end
      1: begin
        write_reg(warc_pkg::REG_MIN_RATE, 32'd1000);
        write_reg(warc_pkg::REG_RUN_LEN,  32'd1);
        write_reg(warc_pkg::REG_MAX_RATE, 32'd1_000_000);
      end
      2: begin
        write_reg(warc_pkg::REG_MIN_RATE, $urandom_range(0, ceiling / 2));
        write_reg(warc_pkg::REG_RUN_LEN,  $urandom_range(2, 20));
        write_reg(warc_pkg::REG_MAX_RATE, ceiling);
      end
      3: begin
        // everything at zero: rate pinned at zero, raise on every shown frame
        write_reg(warc_pkg::REG_MIN_RATE, '0);
        write_reg(warc_pkg::REG_RUN_LEN,  '0);
        write_reg(warc_pkg::REG_MAX_RATE, '0);
      end
      4: begin
        write_reg(warc_pkg::REG_MIN_RATE, 32'd40);
        write_reg(warc_pkg::REG_RUN_LEN,  32'd3);
        write_reg(warc_pkg::REG_MAX_RATE, 32'd50);
      end
      5: begin
        // floor above ceiling
        write_reg(warc_pkg::REG_MIN_RATE, 32'd200);
        write_reg(warc_pkg::REG_RUN_LEN,  32'd5);
        write_reg(warc_pkg::REG_MAX_RATE, 32'd100);
      end
      6: begin
        write_reg(warc_pkg::REG_MIN_RATE, '0);
        write_reg(warc_pkg::REG_RUN_LEN,  $urandom_range(4, 30));
        write_reg(warc_pkg::REG_MAX_RATE, ceiling);
      end
      default: begin
        write_reg(warc_pkg::REG_MIN_RATE, '1);
        write_reg(warc_pkg::REG_RUN_LEN,  32'hFFFF);
        write_reg(warc_pkg::REG_MAX_RATE, '1);
      end
    endcase
    end_writes();
    rx_mode = p % 4;
    quiet   = (p == 2) || (p == 5);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    frame_ch.valid  = 1'b0;
    frame_ch.shown  = 1'b0;
    run_hint        = warc_pkg::RUN_LEN_RST;
    seg_left        = 0;
    drop_pct        = 0;
    burst_left      = 0;
    quiet           = 1'b1;
    rx_mode         = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings
    send_frame(1'b1);
    send_frame(1'b0);
    send_frame(1'b1);

    // unused index must leave every register alone
    go_idle();
    write_reg(REG_UNUSED, $urandom);
    end_writes();
    send_frame(1'b1);

    // zero ceiling, zero floor, zero run length: raise flag with no change
    go_idle();
    write_reg(warc_pkg::REG_RUN_LEN,  '0);
    write_reg(warc_pkg::REG_MIN_RATE, '0);
    write_reg(warc_pkg::REG_MAX_RATE, '0);
    end_writes();
    send_frame(1'b1);
    send_frame(1'b0);
    send_frame(1'b1);

    // tiny rates: 5% rounds to zero so the step is forced to +1, then capped
    go_idle();
    write_reg(warc_pkg::REG_MAX_RATE, 32'd3);
    end_writes();
    send_frame(1'b1);
    send_frame(1'b1);
    send_frame(1'b1);

    // floor above ceiling: drop on a short window never cuts, raise snaps down
    go_idle();
    write_reg(warc_pkg::REG_MIN_RATE, 32'd5000);
    write_reg(warc_pkg::REG_MAX_RATE, 32'd100);
    end_writes();
    send_frame(1'b0);
    send_frame(1'b1);

    // full-scale ceiling: 105% product overflows 32 bits before the cap
    go_idle();
    write_reg(warc_pkg::REG_MIN_RATE, '0);
    write_reg(warc_pkg::REG_MAX_RATE, '1);
    end_writes();
    send_frame(1'b1);
    send_frame(1'b1);

    go_idle();
    write_reg(warc_pkg::REG_RUN_LEN, 32'd2);
    end_writes();
    repeat (4) send_frame(1'b1);

    // random phases, settings from the extremes and in between
    for (int unsigned p = 0; p < PHASES; p++) begin
      set_phase(p);
      send_stream(PHASE_BEATS);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
src/warc_pkg.sv
src/warc_in_if.sv
src/warc_out_if.sv
src/warc_scale.sv
src/windowed_aimd_rate_controller.sv
bench/windowed_aimd_rate_controller_test.sv
